### hw/rtl/lesb_pkg.sv
// Shared constants, payload structs and register codes for the Lees-Edwards
// stream-and-bin unit. No dependencies.

package lesb_pkg;

    localparam int FRAC_W  = 16;
    localparam int POS_W   = 21;
    localparam int INT_W   = POS_W - FRAC_W;
    localparam int VEL_W   = 32;
    localparam int DT_W    = 16;
    localparam int SHIFT_W = 17;
    localparam int CELL_W  = 15;

    localparam int BOX_X_DEF = 32;
    localparam int BOX_Y_DEF = 32;
    localparam int BOX_Z_DEF = 32;

    localparam int NUM_REGS = 7;
    localparam int APB_AW   = $clog2(NUM_REGS) + 2;
    localparam int APB_DW   = 32;

    localparam logic [DT_W-1:0] DT_RESET = 16'd6554;

    typedef enum logic [2:0] {
        REG_TIME_STEP    = 3'd0,
        REG_SHEAR_ENABLE = 3'd1,
        REG_SHEAR_OFFSET = 3'd2,
        REG_SHEAR_SPEED  = 3'd3,
        REG_SHIFT_X      = 3'd4,
        REG_SHIFT_Y      = 3'd5,
        REG_SHIFT_Z      = 3'd6
    } lesb_reg_t;

    typedef struct packed {
        logic                      mode;
        logic [POS_W-1:0]          pos_x;
        logic [POS_W-1:0]          pos_y;
        logic [POS_W-1:0]          pos_z;
        logic signed [VEL_W-1:0]   vel_x;
        logic signed [VEL_W-1:0]   vel_y;
        logic signed [VEL_W-1:0]   vel_z;
    } lesb_particle_t;

    typedef struct packed {
        logic [POS_W-1:0]          new_pos_x;
        logic [POS_W-1:0]          new_pos_y;
        logic [POS_W-1:0]          new_pos_z;
        logic signed [VEL_W-1:0]   new_vel_x;
        logic [CELL_W-1:0]         cell_index;
    } lesb_result_t;

    typedef struct packed {
        logic [DT_W-1:0]           time_step;
        logic                      shear_enable;
        logic [POS_W-1:0]          shear_offset;
        logic signed [VEL_W-1:0]   shear_speed;
        logic signed [SHIFT_W-1:0] shift_x;
        logic signed [SHIFT_W-1:0] shift_y;
        logic signed [SHIFT_W-1:0] shift_z;
    } lesb_cfg_t;

endpackage

### hw/rtl/lesb_stream_if.sv
// Valid/ready stream interface carrying one word of a given payload type.
// No dependencies; the payload type comes from the instantiating code.

interface lesb_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

### hw/rtl/lesb_cfg.sv
// APB-style configuration register file for the stream-and-bin unit.
// Depends on lesb_pkg.

module lesb_cfg
    import lesb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output lesb_cfg_t         cfg
);

    lesb_cfg_t cfg_reg;
    lesb_cfg_t cfg_next;
    lesb_reg_t idx;
    logic      wr_en;

    assign idx    = lesb_reg_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_TIME_STEP:    cfg_next.time_step    = pwdata[DT_W-1:0];
                REG_SHEAR_ENABLE: cfg_next.shear_enable = pwdata[0];
                REG_SHEAR_OFFSET: cfg_next.shear_offset = pwdata[POS_W-1:0];
                REG_SHEAR_SPEED:  cfg_next.shear_speed  = $signed(pwdata[VEL_W-1:0]);
                REG_SHIFT_X:      cfg_next.shift_x      = $signed(pwdata[SHIFT_W-1:0]);
                REG_SHIFT_Y:      cfg_next.shift_y      = $signed(pwdata[SHIFT_W-1:0]);
                REG_SHIFT_Z:      cfg_next.shift_z      = $signed(pwdata[SHIFT_W-1:0]);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TIME_STEP:    prdata = APB_DW'(cfg_reg.time_step);
            REG_SHEAR_ENABLE: prdata = APB_DW'(cfg_reg.shear_enable);
            REG_SHEAR_OFFSET: prdata = APB_DW'(cfg_reg.shear_offset);
            REG_SHEAR_SPEED:  prdata = APB_DW'(cfg_reg.shear_speed);
            REG_SHIFT_X:      prdata = APB_DW'(cfg_reg.shift_x);
            REG_SHIFT_Y:      prdata = APB_DW'(cfg_reg.shift_y);
            REG_SHIFT_Z:      prdata = APB_DW'(cfg_reg.shift_z);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step    <= DT_RESET;
            cfg_reg.shear_enable <= 1'b0;
            cfg_reg.shear_offset <= '0;
            cfg_reg.shear_speed  <= '0;
            cfg_reg.shift_x      <= '0;
            cfg_reg.shift_y      <= '0;
            cfg_reg.shift_z      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hw/rtl/lesb_wrap.sv
// Two-stage periodic wrap of a signed Q.16 value into [0, BOX) box units:
// reciprocal multiply, then one correction step. Depends on lesb_pkg.

module lesb_wrap
    import lesb_pkg::*;
#(
    parameter int W   = 34,
    parameter int BOX = BOX_X_DEF
)
(
    input  logic                       clk,
    input  logic                       en_mul,
    input  logic                       en_fix,
    input  logic signed [W-1:0]        a,
    output logic signed [W-FRAC_W-1:0] q,
    output logic [POS_W-1:0]           r
);

    localparam int IW = W - FRAC_W;
    localparam int UW = IW - 1 + $clog2(BOX + 1);
    localparam int MW = UW + 1;
    localparam int PW = UW + MW;

    localparam logic [UW-1:0] OFS   = UW'(longint'(BOX) << (IW - 1));
    localparam logic [UW-1:0] QBIAS = UW'(longint'(1) << (IW - 1));
    localparam logic [UW-1:0] BOXU  = UW'(BOX);
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << UW) / BOX);

    logic [UW-1:0]     u;
    logic [PW-1:0]     prod;
    logic [UW-1:0]     u_reg;
    logic [UW-1:0]     q0_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [UW-1:0]     rem;
    logic              fix;
    logic [UW-1:0]     rint;
    logic [UW-1:0]     qb;
    logic signed [IW-1:0] q_next;
    logic [POS_W-1:0]  r_next;
    logic signed [IW-1:0] q_reg;
    logic [POS_W-1:0]  r_reg;

    // bias the integer part so it is never negative, then divide by BOX
    assign u    = UW'($signed(a[W-1:FRAC_W])) + OFS;
    assign prod = PW'(u) * PW'(RECIP);

    // estimate is exact or one low
    assign rem    = u_reg - q0_reg * BOXU;
    assign fix    = (rem >= BOXU);
    assign rint   = fix ? rem - BOXU : rem;
    assign qb     = q0_reg + UW'(fix) - QBIAS;
    assign q_next = $signed(qb[IW-1:0]);
    assign r_next = {rint[INT_W-1:0], frac_reg};

    assign q = q_reg;
    assign r = r_reg;

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            u_reg    <= u;
            q0_reg   <= prod[PW-2:UW];
            frac_reg <= a[FRAC_W-1:0];
        end
        if (en_fix)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

endmodule

### hw/rtl/lees_edwards_stream_and_bin_unit.sv
// Lees-Edwards stream-and-bin unit: move, periodic or sheared wrap and cell index of a particle.
// Depends on lesb_pkg, lesb_stream_if, lesb_cfg, lesb_wrap.
// Eight register stages counting the input register, two of them per pass through a wrap unit.
// Throughput: one word per cycle; a stage holds only while the next one is full and stalled.
// Reset clears the stage valid bits and loads the register reset values.

module lees_edwards_stream_and_bin_unit
    import lesb_pkg::*;
#(
    parameter int BOX_X = BOX_X_DEF,
    parameter int BOX_Y = BOX_Y_DEF,
    parameter int BOX_Z = BOX_Z_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    lesb_stream_if.sink       particle,
    lesb_stream_if.source     result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int NSTG = 8;
    localparam int MULW = VEL_W + DT_W + 1;
    localparam int PW   = VEL_W + 2;
    localparam int QW   = PW - FRAC_W;
    localparam int XW   = QW + POS_W + 1;
    localparam int SW   = QW + VEL_W;
    localparam int NW   = SW + 1;

    localparam logic [CELL_W-1:0] ROW_STEP   = CELL_W'(BOX_X);
    localparam logic [CELL_W-1:0] PLANE_STEP = CELL_W'(BOX_X * BOX_Y);

    lesb_cfg_t cfg;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;

    lesb_particle_t s1_reg;

    logic signed [DT_W:0]    dt_s;
    logic signed [MULW-1:0]  prod_x;
    logic signed [MULW-1:0]  prod_y;
    logic signed [MULW-1:0]  prod_z;
    logic signed [PW-1:0]    mov_x;
    logic signed [PW-1:0]    mov_y;
    logic signed [PW-1:0]    mov_z;
    logic signed [PW-1:0]    px_next;
    logic signed [PW-1:0]    py_next;
    logic signed [PW-1:0]    pz_next;

    logic signed [PW-1:0]    px_s2_reg;
    logic signed [PW-1:0]    py_s2_reg;
    logic signed [PW-1:0]    pz_s2_reg;
    logic signed [VEL_W-1:0] vx_s2_reg;
    logic signed [PW-1:0]    px_s3_reg;
    logic signed [VEL_W-1:0] vx_s3_reg;
    logic signed [PW-1:0]    px_s4_reg;
    logic signed [VEL_W-1:0] vx_s4_reg;

    logic signed [QW-1:0]    cy;
    logic [POS_W-1:0]        rx;
    logic [POS_W-1:0]        ry;
    logic [POS_W-1:0]        rz;

    logic signed [POS_W:0]   off_s;
    logic signed [XW-1:0]    xs_next;
    logic signed [SW-1:0]    sv_next;
    logic signed [XW-1:0]    xs_s5_reg;
    logic signed [SW-1:0]    sv_s5_reg;
    logic signed [VEL_W-1:0] vx_s5_reg;
    logic [POS_W-1:0]        rx_s5_reg;
    logic [POS_W-1:0]        ry_s5_reg;
    logic [POS_W-1:0]        rz_s5_reg;

    logic signed [NW-1:0]    nv;
    logic                    nv_fits;
    logic signed [VEL_W-1:0] nv_sat;
    logic signed [VEL_W-1:0] vxo_next;
    logic signed [VEL_W-1:0] vxo_s6_reg;
    logic signed [VEL_W-1:0] vxo_s7_reg;
    logic [POS_W-1:0]        rx_s6_reg;
    logic [POS_W-1:0]        ry_s6_reg;
    logic [POS_W-1:0]        rz_s6_reg;
    logic [POS_W-1:0]        rx_s7_reg;
    logic [POS_W-1:0]        ry_s7_reg;
    logic [POS_W-1:0]        rz_s7_reg;
    logic [POS_W-1:0]        rxs;

    lesb_result_t            out_next;
    lesb_result_t            out_reg;

    lesb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage k loads when it is empty or its contents move on
    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || result.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign particle.ready = adv[0];
    assign result.valid   = vld_reg[NSTG-1];
    assign result.word    = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= particle.valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // move: v*dt floored to Q16.16, or the shift vector
    assign dt_s   = $signed({1'b0, cfg.time_step});
    assign prod_x = MULW'(s1_reg.vel_x) * MULW'(dt_s);
    assign prod_y = MULW'(s1_reg.vel_y) * MULW'(dt_s);
    assign prod_z = MULW'(s1_reg.vel_z) * MULW'(dt_s);

    assign mov_x = s1_reg.mode ? PW'(cfg.shift_x) : PW'($signed(prod_x[MULW-1:FRAC_W]));
    assign mov_y = s1_reg.mode ? PW'(cfg.shift_y) : PW'($signed(prod_y[MULW-1:FRAC_W]));
    assign mov_z = s1_reg.mode ? PW'(cfg.shift_z) : PW'($signed(prod_z[MULW-1:FRAC_W]));

    assign px_next = $signed(PW'(s1_reg.pos_x)) + mov_x;
    assign py_next = $signed(PW'(s1_reg.pos_y)) + mov_y;
    assign pz_next = $signed(PW'(s1_reg.pos_z)) + mov_z;

    lesb_wrap #(.W(PW), .BOX(BOX_X)) u_wrap_x (
        .clk    (clk),
        .en_mul (adv[2]),
        .en_fix (adv[3]),
        .a      (px_s2_reg),
        .q      (),
        .r      (rx)
    );

    lesb_wrap #(.W(PW), .BOX(BOX_Y)) u_wrap_y (
        .clk    (clk),
        .en_mul (adv[2]),
        .en_fix (adv[3]),
        .a      (py_s2_reg),
        .q      (cy),
        .r      (ry)
    );

    lesb_wrap #(.W(PW), .BOX(BOX_Z)) u_wrap_z (
        .clk    (clk),
        .en_mul (adv[2]),
        .en_fix (adv[3]),
        .a      (pz_s2_reg),
        .q      (),
        .r      (rz)
    );

    // shear image correction terms
    assign off_s   = $signed({1'b0, cfg.shear_offset});
    assign xs_next = XW'(px_s4_reg) - XW'(cy) * XW'(off_s);
    assign sv_next = SW'(cy) * SW'(cfg.shear_speed);

    lesb_wrap #(.W(XW), .BOX(BOX_X)) u_wrap_xs (
        .clk    (clk),
        .en_mul (adv[5]),
        .en_fix (adv[6]),
        .a      (xs_s5_reg),
        .q      (),
        .r      (rxs)
    );

    assign nv      = NW'(vx_s5_reg) - NW'(sv_s5_reg);
    assign nv_fits = (&nv[NW-1:VEL_W-1]) || !(|nv[NW-1:VEL_W-1]);
    assign nv_sat  = nv_fits ? $signed(nv[VEL_W-1:0])
                   : (nv[NW-1] ? $signed({1'b1, {(VEL_W-1){1'b0}}})
                               : $signed({1'b0, {(VEL_W-1){1'b1}}}));
    assign vxo_next = cfg.shear_enable ? nv_sat : vx_s5_reg;

    always_comb
    begin
        out_next.new_pos_x  = cfg.shear_enable ? rxs : rx_s7_reg;
        out_next.new_pos_y  = ry_s7_reg;
        out_next.new_pos_z  = rz_s7_reg;
        out_next.new_vel_x  = vxo_s7_reg;
        out_next.cell_index = CELL_W'(out_next.new_pos_x[POS_W-1:FRAC_W])
                            + CELL_W'(ry_s7_reg[POS_W-1:FRAC_W]) * ROW_STEP
                            + CELL_W'(rz_s7_reg[POS_W-1:FRAC_W]) * PLANE_STEP;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_reg <= particle.word;
        end
        if (adv[1])
        begin
            px_s2_reg <= px_next;
            py_s2_reg <= py_next;
            pz_s2_reg <= pz_next;
            vx_s2_reg <= s1_reg.vel_x;
        end
        if (adv[2])
        begin
            px_s3_reg <= px_s2_reg;
            vx_s3_reg <= vx_s2_reg;
        end
        if (adv[3])
        begin
            px_s4_reg <= px_s3_reg;
            vx_s4_reg <= vx_s3_reg;
        end
        if (adv[4])
        begin
            xs_s5_reg <= xs_next;
            sv_s5_reg <= sv_next;
            vx_s5_reg <= vx_s4_reg;
            rx_s5_reg <= rx;
            ry_s5_reg <= ry;
            rz_s5_reg <= rz;
        end
        if (adv[5])
        begin
            vxo_s6_reg <= vxo_next;
            rx_s6_reg  <= rx_s5_reg;
            ry_s6_reg  <= ry_s5_reg;
            rz_s6_reg  <= rz_s5_reg;
        end
        if (adv[6])
        begin
            vxo_s7_reg <= vxo_s6_reg;
            rx_s7_reg  <= rx_s6_reg;
            ry_s7_reg  <= ry_s6_reg;
            rz_s7_reg  <= rz_s6_reg;
        end
        if (adv[7])
        begin
            out_reg <= out_next;
        end
    end

endmodule

### bench/tb.sv
// Testbench for lees_edwards_stream_and_bin_unit: a directed table, then random phases,
// with every result checked in order against a table value or the in-bench predictor.
// Depends on lesb_pkg, lesb_stream_if and lees_edwards_stream_and_bin_unit.
`timescale 1ns / 1ps

module tb;
    import lesb_pkg::*;

    localparam int     BOX_X        = 32;
    localparam int     BOX_Y        = 32;
    localparam int     BOX_Z        = 32;
    localparam longint ONE_Q        = longint'(1) << FRAC_W;
    localparam int     LATENCY      = 8;
    localparam int     DRAIN_CYCLES = LATENCY + 8;
    localparam int     NUM_PHASES   = 8;
    localparam int     PHASE_ITEMS  = 240;
    localparam int     LOG_CAP      = 50;
    localparam longint LIMIT_NS     = 64'd5_000_000;
    localparam int     REG_UNUSED_IDX = NUM_REGS;

    localparam logic MODE_STREAM = 1'b0;
    localparam logic MODE_SHIFT  = 1'b1;

    typedef enum int {
        TRAFFIC_STEADY,
        TRAFFIC_SRC_GAPS,
        TRAFFIC_SINK_STALL,
        TRAFFIC_BOTH
    } traffic_t;

    typedef enum int {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t      kind;
        int             reg_idx;
        logic [31:0]    value;
        lesb_particle_t word;
        bit             typed;
        lesb_result_t   want;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    lesb_stream_if #(.word_t(lesb_particle_t)) particle_if ();
    lesb_stream_if #(.word_t(lesb_result_t))   result_if ();

    lesb_result_t moves_due[$];
    stim_row_t    stim_plan[$];
    lesb_cfg_t    cfg_now;
    traffic_t     traffic;
    int           fail_count;

    lees_edwards_stream_and_bin_unit #(
        .BOX_X(BOX_X),
        .BOX_Y(BOX_Y),
        .BOX_Z(BOX_Z)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .particle(particle_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("[lees_edwards_stream_and_bin_unit] ERROR");
        $finish;
    end

    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint floor_mod(input longint a, input longint b);
        return a - b * floor_div(a, b);
    endfunction

    function automatic lesb_result_t predict_move(input lesb_particle_t p, input lesb_cfg_t c);
        lesb_result_t r;
        longint lx, ly, lz;
        longint px, py, pz, vx, vy, vz, dt, cy, nv;
        lx = longint'(BOX_X) * ONE_Q;
        ly = longint'(BOX_Y) * ONE_Q;
        lz = longint'(BOX_Z) * ONE_Q;
        px = longint'(p.pos_x);
        py = longint'(p.pos_y);
        pz = longint'(p.pos_z);
        vx = longint'($signed(p.vel_x));
        vy = longint'($signed(p.vel_y));
        vz = longint'($signed(p.vel_z));
        dt = longint'(c.time_step);
        if (p.mode == MODE_STREAM)
        begin
            px = px + floor_div(vx * dt, ONE_Q);
            py = py + floor_div(vy * dt, ONE_Q);
            pz = pz + floor_div(vz * dt, ONE_Q);
        end
        else
        begin
            px = px + longint'($signed(c.shift_x));
            py = py + longint'($signed(c.shift_y));
            pz = pz + longint'($signed(c.shift_z));
        end
        if (c.shear_enable)
        begin
            cy = floor_div(py, ly);
            px = floor_mod(px - cy * longint'(c.shear_offset), lx);
            py = py - cy * ly;
            nv = vx - cy * longint'($signed(c.shear_speed));
            if (nv > longint'(32'sh7FFF_FFFF))
                nv = longint'(32'sh7FFF_FFFF);
            if (nv < -longint'(64'h8000_0000))
                nv = -longint'(64'h8000_0000);
            vx = nv;
        end
        else
        begin
            px = floor_mod(px, lx);
            py = floor_mod(py, ly);
        end
        pz = floor_mod(pz, lz);
        r.new_pos_x  = POS_W'(px);
        r.new_pos_y  = POS_W'(py);
        r.new_pos_z  = POS_W'(pz);
        r.new_vel_x  = VEL_W'(vx);
        r.cell_index = CELL_W'(px / ONE_Q + longint'(BOX_X) * (py / ONE_Q)
                               + longint'(BOX_X * BOX_Y) * (pz / ONE_Q));
        return r;
    endfunction

    function automatic int gap_pct(input bit sink_side);
        case (traffic)
            TRAFFIC_SRC_GAPS:   return sink_side ? 0 : 66;
            TRAFFIC_SINK_STALL: return sink_side ? 66 : 0;
            TRAFFIC_BOTH:       return 18;
            default:            return 0;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < LOG_CAP)
            $display("%0t mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_move(input lesb_result_t got);
        lesb_result_t want;
        if (moves_due.size() == 0)
            report_mismatch($sformatf("result word with nothing outstanding: %h", got));
        else
        begin
            want = moves_due.pop_front();
            if (got.new_pos_x !== want.new_pos_x)
                report_mismatch($sformatf("new_pos_x %h want %h", got.new_pos_x, want.new_pos_x));
            if (got.new_pos_y !== want.new_pos_y)
                report_mismatch($sformatf("new_pos_y %h want %h", got.new_pos_y, want.new_pos_y));
            if (got.new_pos_z !== want.new_pos_z)
                report_mismatch($sformatf("new_pos_z %h want %h", got.new_pos_z, want.new_pos_z));
            if (got.new_vel_x !== want.new_vel_x)
                report_mismatch($sformatf("new_vel_x %h want %h", got.new_vel_x, want.new_vel_x));
            if (got.cell_index !== want.cell_index)
                report_mismatch($sformatf("cell_index %h want %h",
                                          got.cell_index, want.cell_index));
        end
    endtask

    // result side: check on handshake, then pick next ready
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready)
                check_move(result_if.word);
            result_if.ready <= rst_n && ($urandom_range(0, 99) >= gap_pct(1'b1));
        end
    end

    task automatic send_particle(input lesb_particle_t p, input lesb_result_t want);
        while ($urandom_range(0, 99) < gap_pct(1'b0))
        begin
            particle_if.valid <= 1'b0;
            @(posedge clk);
        end
        particle_if.valid <= 1'b1;
        particle_if.word  <= p;
        do @(posedge clk); while (!particle_if.ready);
        moves_due = {moves_due, want};
    endtask

    task automatic settle_pipe();
        particle_if.valid <= 1'b0;
        while (moves_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_TIME_STEP:    cfg_now.time_step    = value[DT_W-1:0];
            REG_SHEAR_ENABLE: cfg_now.shear_enable = value[0];
            REG_SHEAR_OFFSET: cfg_now.shear_offset = value[POS_W-1:0];
            REG_SHEAR_SPEED:  cfg_now.shear_speed  = value[VEL_W-1:0];
            REG_SHIFT_X:      cfg_now.shift_x      = value[SHIFT_W-1:0];
            REG_SHIFT_Y:      cfg_now.shift_y      = value[SHIFT_W-1:0];
            REG_SHIFT_Z:      cfg_now.shift_z      = value[SHIFT_W-1:0];
            default:          ;
        endcase
    endtask

    function automatic lesb_particle_t make_particle(input logic m,
                                                     input logic [POS_W-1:0] px,
                                                     input logic [POS_W-1:0] py,
                                                     input logic [POS_W-1:0] pz,
                                                     input logic [VEL_W-1:0] vx,
                                                     input logic [VEL_W-1:0] vy,
                                                     input logic [VEL_W-1:0] vz);
        lesb_particle_t p;
        p.mode  = m;
        p.pos_x = px;
        p.pos_y = py;
        p.pos_z = pz;
        p.vel_x = vx;
        p.vel_y = vy;
        p.vel_z = vz;
        return p;
    endfunction

    function automatic lesb_result_t make_move(input logic [POS_W-1:0] px,
                                               input logic [POS_W-1:0] py,
                                               input logic [POS_W-1:0] pz,
                                               input logic [VEL_W-1:0] vx,
                                               input logic [CELL_W-1:0] cell_idx);
        lesb_result_t r;
        r.new_pos_x  = px;
        r.new_pos_y  = py;
        r.new_pos_z  = pz;
        r.new_vel_x  = vx;
        r.cell_index = cell_idx;
        return r;
    endfunction

    function automatic void add_item(input lesb_particle_t p, input bit typed,
                                     input lesb_result_t want);
        stim_row_t row;
        row.kind    = ROW_ITEM;
        row.reg_idx = 0;
        row.value   = '0;
        row.word    = p;
        row.typed   = typed;
        row.want    = want;
        stim_plan = {stim_plan, row};
    endfunction

    function automatic void add_write(input int idx, input logic [31:0] value);
        stim_row_t row;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.value   = value;
        row.word    = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        stim_plan = {stim_plan, row};
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 3))
            0:       return POS_W'($urandom_range(0, 127));
            1:       return POS_W'(21'h1F_FFFF - $urandom_range(0, 127));
            2:       return {INT_W'($urandom()), ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
            default: return POS_W'($urandom());
        endcase
    endfunction

    function automatic logic [VEL_W-1:0] rand_vel();
        case ($urandom_range(0, 4))
            0:       return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
            1:       return 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] dirty(input logic [31:0] v, input int w);
        logic [31:0] mask;
        mask = 32'((64'd1 << w) - 1);
        return (v & mask) | ($urandom() & ~mask);
    endfunction

    initial
    begin
        lesb_particle_t p;
        logic [31:0]    ts, en, off, spd, sx, sy, sz;

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        particle_if.valid = 1'b0;
        particle_if.word  = '0;
        fail_count        = 0;
        traffic           = TRAFFIC_STEADY;

        cfg_now              = '0;
        cfg_now.time_step    = DT_RESET;

        // reset config
        add_item(make_particle(MODE_STREAM, 0, 0, 0, 0, 0, 0), 1'b1,
                 make_move(0, 0, 0, 0, 0));
        add_item(make_particle(MODE_STREAM, 21'h1F_FFFF, 21'h1F_FFFF, 21'h1F_FFFF, 0, 0, 0),
                 1'b1, make_move(21'h1F_FFFF, 21'h1F_FFFF, 21'h1F_FFFF, 0, 15'h7FFF));
        add_item(make_particle(MODE_STREAM, 0, 0, 0, 32'hFFFF_FFFF, 0, 0), 1'b1,
                 make_move(21'h1F_FFFF, 0, 0, 32'hFFFF_FFFF, 15'd31));
        add_item(make_particle(MODE_STREAM, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF), 1'b0, '0);
        add_item(make_particle(MODE_STREAM, 21'h1F_FFFF, 21'h1F_FFFF, 21'h1F_FFFF,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0, '0);
        add_item(make_particle(MODE_SHIFT, 21'h01_2345, 21'h00_ABCD, 21'h1F_0000,
                               32'h1234_5678, 32'hFFFF_FFFF, 0), 1'b1,
                 make_move(21'h01_2345, 21'h00_ABCD, 21'h1F_0000, 32'h1234_5678, 15'd31745));
        // negative product floors down
        add_item(make_particle(MODE_STREAM, 21'h01_0000, 21'h01_0000, 21'h01_0000,
                               32'hFFFF_FFFD, 32'hFFFF_FFFD, 32'h0000_0003), 1'b0, '0);

        add_write(REG_TIME_STEP, 32'h0000_FFFF);
        add_write(REG_SHIFT_X, 32'h0001_0000);
        add_write(REG_SHIFT_Y, 32'h0000_FFFF);
        add_write(REG_SHIFT_Z, 32'h0000_8000);
        add_item(make_particle(MODE_SHIFT, 0, 0, 0, 32'h0000_1000, 0, 0), 1'b0, '0);
        add_item(make_particle(MODE_SHIFT, 21'h1F_FFFF, 21'h1F_FFFF, 21'h1F_FFFF,
                               32'h8000_0000, 0, 0), 1'b0, '0);
        add_item(make_particle(MODE_STREAM, 21'h10_0000, 21'h10_0000, 21'h10_0000,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0, '0);

        add_write(REG_SHEAR_ENABLE, 32'h0000_0001);
        add_write(REG_SHEAR_OFFSET, 32'h001F_FFFF);
        add_write(REG_SHEAR_SPEED, 32'h7FFF_FFFF);
        add_item(make_particle(MODE_STREAM, 21'h00_8000, 21'h1F_0000, 0,
                               32'h8000_0000, 32'h7FFF_FFFF, 0), 1'b0, '0);
        add_item(make_particle(MODE_STREAM, 21'h00_8000, 0, 0,
                               32'h7FFF_FFFF, 32'h8000_0000, 0), 1'b0, '0);
        add_item(make_particle(MODE_SHIFT, 21'h0A_0000, 21'h1F_FFFF, 0,
                               32'h0001_0000, 0, 0), 1'b0, '0);
        add_item(make_particle(MODE_STREAM, 21'h0A_0000, 0, 0,
                               32'h0001_0000, 32'hFFFF_FFFF, 0), 1'b0, '0);

        add_write(REG_SHEAR_SPEED, 32'h8000_0000);
        add_write(REG_SHEAR_OFFSET, 32'h0000_0000);
        add_item(make_particle(MODE_STREAM, 21'h00_0001, 21'h1F_FFFF, 21'h00_0001,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0);
        add_item(make_particle(MODE_STREAM, 21'h00_0001, 0, 21'h00_0001,
                               32'h8000_0000, 32'h8000_0000, 0), 1'b0, '0);

        // unmapped index must leave every register untouched
        add_write(REG_UNUSED_IDX, 32'hFFFF_FFFF);
        add_item(make_particle(MODE_STREAM, 21'h05_4321, 21'h1E_0000, 21'h07_7777,
                               32'h0123_4567, 32'h00F0_0000, 32'hFEDC_BA98), 1'b0, '0);

        add_write(REG_TIME_STEP, 32'h0000_0000);
        add_item(make_particle(MODE_STREAM, 21'h0F_0F0F, 21'h10_F0F0, 21'h1A_5A5A,
                               32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 1'b0, '0);
        add_write(REG_SHEAR_ENABLE, 32'h0000_0000);
        add_item(make_particle(MODE_SHIFT, 21'h1F_FFFF, 21'h1F_FFFF, 21'h1F_FFFF,
                               32'h8000_0000, 0, 0), 1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_plan[i])
        begin
            if (stim_plan[i].kind == ROW_WRITE)
            begin
                if (i > 0 && stim_plan[i-1].kind == ROW_ITEM)
                    settle_pipe();
                write_reg(stim_plan[i].reg_idx, stim_plan[i].value);
            end
            else if (stim_plan[i].typed)
                send_particle(stim_plan[i].word, stim_plan[i].want);
            else
                send_particle(stim_plan[i].word, predict_move(stim_plan[i].word, cfg_now));
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle_pipe();
            traffic = traffic_t'(ph % 4);
            if (ph == 0)
            begin
                ts  = 32'h0000_0000;
                en  = 32'h0000_0001;
                off = 32'h0000_0000;
                spd = 32'h8000_0000;
                sx  = 32'h0001_0000;
                sy  = 32'h0001_0000;
                sz  = 32'h0001_0000;
            end
            else if (ph == 1)
            begin
                ts  = 32'h0000_FFFF;
                en  = 32'h0000_0001;
                off = 32'h001F_FFFF;
                spd = 32'h7FFF_FFFF;
                sx  = 32'h0000_FFFF;
                sy  = 32'h0000_FFFF;
                sz  = 32'h0000_FFFF;
            end
            else
            begin
                ts  = dirty($urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(0, 8000),
                            DT_W);
                en  = dirty(32'($urandom_range(0, 3) != 0), 1);
                off = dirty($urandom(), POS_W);
                spd = $urandom_range(0, 1) ? $urandom()
                                           : 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
                sx  = dirty($urandom(), SHIFT_W);
                sy  = dirty($urandom(), SHIFT_W);
                sz  = dirty($urandom(), SHIFT_W);
            end
            write_reg(REG_TIME_STEP, ts);
            write_reg(REG_SHEAR_ENABLE, en);
            write_reg(REG_SHEAR_OFFSET, off);
            write_reg(REG_SHEAR_SPEED, spd);
            write_reg(REG_SHIFT_X, sx);
            write_reg(REG_SHIFT_Y, sy);
            write_reg(REG_SHIFT_Z, sz);
            if (ph == 3)
                write_reg(REG_UNUSED_IDX, $urandom());

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                p = make_particle(($urandom_range(0, 99) < 60) ? MODE_STREAM : MODE_SHIFT,
                                  rand_pos(), rand_pos(), rand_pos(),
                                  rand_vel(), rand_vel(), rand_vel());
                send_particle(p, predict_move(p, cfg_now));
            end
        end

        settle_pipe();
        if (fail_count == 0)
            $display("[lees_edwards_stream_and_bin_unit] OK");
        else
            $display("[lees_edwards_stream_and_bin_unit] ERROR");
        $finish;
    end

endmodule
